[design/assert_macros.svh]
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under a clock with a reset that disables it
`define NSCI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition in this cycle implies an expression in the next one
`define NSCI_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[design/nsci_pkg.sv]
// ----------------------------------------------------------------------------
// nsci_pkg
// Types, constants and helpers of the Newton-Schulz complex inverse unit.
// ----------------------------------------------------------------------------
package nsci_pkg;

   // matrix geometry
   localparam int DIM    = 8;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 32;
   localparam int CPLX_W = 2 * DATA_W;
   localparam int FRAC_W = 24;

   // accumulator width: sixteen floored terms of about 40 bits each
   localparam int ACC_W  = 48;

   // token counter: element index k and part of the complex product
   localparam int CNT_W  = IDX_W + 2;
   // norm step counter: element index and real or imaginary half
   localparam int NRM_W  = IDX_W + 1;

   // square root unit
   localparam int SQRT_STEPS = 32;
   localparam int SQRT_CNT_W = 5;
   localparam int REM_W      = 35;

   localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(64'd1 << FRAC_W);

   // commands
   localparam logic [1:0] CMD_LOAD_A = 2'd0;
   localparam logic [1:0] CMD_LOAD_X = 2'd1;
   localparam logic [1:0] CMD_START  = 2'd2;
   localparam logic [1:0] CMD_SPARE  = 2'd3;

   // result status
   localparam logic [1:0] STAT_CONVERGED = 2'd0;
   localparam logic [1:0] STAT_LIMIT     = 2'd1;
   localparam logic [1:0] STAT_UNSTABLE  = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_TOLERANCE   = 2'd0;
   localparam logic [1:0] CSR_FLUCTUATION = 2'd1;
   localparam logic [1:0] CSR_LIMIT       = 2'd2;

   // parts of one complex term, in feed order
   localparam logic [1:0] PART_RR = 2'd0;
   localparam logic [1:0] PART_II = 2'd1;
   localparam logic [1:0] PART_RI = 2'd2;
   localparam logic [1:0] PART_IR = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] re;
      logic [DATA_W-1:0] im;
   } cplx_type;

   typedef cplx_type [DIM-1:0] row_type;

   // one beat handed along the cell chain
   typedef struct packed {
      logic              valid;
      logic              head;
      logic              tail;
      logic [1:0]        part;
      logic [DATA_W-1:0] a;
      row_type           qrow;
   } token_type;

   typedef struct packed {
      logic     done;
      cplx_type value;
   } cell_res_type;

   typedef struct packed {
      logic [DIM-1:0]   wr_lane;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_ctl_type;

   // sign extension of a data word to accumulator width
   function automatic logic signed [ACC_W-1:0] ext_acc(input logic [DATA_W-1:0] v);
      ext_acc = {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

   // saturate an accumulator value to a data word
   function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DATA_W:0] upper;
      upper = v[ACC_W-1:DATA_W-1];
      if ((&upper) || !(|upper)) begin
         sat32 = v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         sat32 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat32 = {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

[design/nsci_row_ram.sv]
// ----------------------------------------------------------------------------
// nsci_row_ram
// Matrix store, one row per word, lane write enables and a registered read.
// ----------------------------------------------------------------------------
module nsci_row_ram (
   input  logic                  clock,
   input  nsci_pkg::ram_ctl_type ctl,
   input  nsci_pkg::row_type     wr_data,
   output nsci_pkg::row_type     rd_data
);
   import nsci_pkg::*;

   row_type mem [DIM];
   row_type rd_data_ff;

   // lane writes
   always_ff @(posedge clock) begin
      for (int lane = 0; lane < DIM; lane++) begin
         if (ctl.wr_lane[lane]) begin
            mem[ctl.wr_addr][lane] <= wr_data[lane];
         end
      end
   end

   // registered read, held between reads
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/nsci_cell.sv]
// ----------------------------------------------------------------------------
// nsci_cell
// One product cell: multiplies the passing operand by its column element,
// accumulates one complex result and hands the beat to its neighbor.
// ----------------------------------------------------------------------------
module nsci_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  nsci_pkg::token_type    tok_in,
   output nsci_pkg::token_type    tok_out,
   output nsci_pkg::cell_res_type res
);
   import nsci_pkg::*;

   token_type               tok_ff;
   logic signed [CPLX_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  sr_ff;
   logic signed [ACC_W-1:0]  si_ff;
   logic signed [ACC_W-1:0]  sr_in;
   logic signed [ACC_W-1:0]  si_in;
   logic signed [ACC_W-1:0]  base_r;
   logic signed [ACC_W-1:0]  base_i;
   logic signed [ACC_W-1:0]  term;
   logic [DATA_W-1:0]        b_sel;
   logic                     done_ff;

   // column operand for this part of the complex term
   always_comb begin
      unique case (tok_in.part)
         PART_RR, PART_IR: b_sel = tok_in.qrow[0].re;
         PART_II, PART_RI: b_sel = tok_in.qrow[0].im;
      endcase
   end

   // beat register and product register
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         tok_ff  <= tok_in;
         done_ff <= tok_ff.valid && tok_ff.tail;
      end
      prod_ff <= $signed(tok_in.a) * $signed(b_sel);
   end

   // floored product term
   assign term = ACC_W'(prod_ff >>> FRAC_W);

   // accumulate
   always_comb begin
      base_r = tok_ff.head ? '0 : sr_ff;
      base_i = tok_ff.head ? '0 : si_ff;
      sr_in  = sr_ff;
      si_in  = si_ff;
      if (tok_ff.valid) begin
         sr_in = base_r;
         si_in = base_i;
         unique case (tok_ff.part)
            PART_RR:          sr_in = base_r + term;
            PART_II:          sr_in = base_r - term;
            PART_RI, PART_IR: si_in = base_i + term;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      si_ff <= si_in;
   end

   // pass the beat on, column row moved down by one element
   always_comb begin
      tok_out      = tok_ff;
      tok_out.qrow = row_type'(tok_ff.qrow >> CPLX_W);
   end

   assign res.done     = done_ff;
   assign res.value.re = sat32(sr_ff);
   assign res.value.im = sat32(si_ff);

endmodule

[design/nsci_sqrt.sv]
// ----------------------------------------------------------------------------
// nsci_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module nsci_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [nsci_pkg::CPLX_W-1:0] radicand,
   output logic                        done,
   output logic [nsci_pkg::DATA_W-1:0] root
);
   import nsci_pkg::*;

   logic [CPLX_W-1:0]     rad_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [DATA_W-1:0]     root_ff;
   logic [SQRT_CNT_W-1:0] cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      trial;
   logic                  ge;

   // one digit of the restoring square root
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[CPLX_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= ge ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[DATA_W-2:0], ge};
            cnt_ff  <= cnt_ff + SQRT_CNT_W'(1);
            if (cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[design/newton_schulz_complex_inverse_unit.sv]
// ----------------------------------------------------------------------------
// newton_schulz_complex_inverse_unit
// Complex matrix inverse by Newton-Schulz refinement, Q8.24 fixed point.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  cmd, row, col, real, imag
//   rsp       out         rsp_valid / rsp_stall  out_row, out_col, real, imag,
//                                                status, last
//   csr       in          csr_write              csr_index, csr_data
//
// A start runs each refinement step on a chain of DIM product cells fed one
// beat per part of each complex term; a product row is fed, drained and
// written back, with a norm pass over I - AX and a square root of its sum
// before the second product; a run ends in DIM*DIM result beats with one
// store read per row. req_stall is high from start until the last beat is
// taken; rsp_stall holds the current beat. Synchronous reset, no clearing pass.
//
module newton_schulz_complex_inverse_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [nsci_pkg::IDX_W-1:0]  req_row,
   input  logic [nsci_pkg::IDX_W-1:0]  req_col,
   input  logic signed [31:0]          req_real_part,
   input  logic signed [31:0]          req_imag_part,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [nsci_pkg::IDX_W-1:0]  rsp_out_row,
   output logic [nsci_pkg::IDX_W-1:0]  rsp_out_col,
   output logic signed [31:0]          rsp_out_real,
   output logic signed [31:0]          rsp_out_imag,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last,
   input  logic                        csr_write,
   input  logic [1:0]                  csr_index,
   input  logic [30:0]                 csr_data
);
   import nsci_pkg::*;

   // sequencer codes
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHECK   = 4'd1;
   localparam logic [3:0] S_PREP    = 4'd2;
   localparam logic [3:0] S_MUL     = 4'd3;
   localparam logic [3:0] S_WAIT    = 4'd4;
   localparam logic [3:0] S_NORM    = 4'd5;
   localparam logic [3:0] S_WRITE   = 4'd6;
   localparam logic [3:0] S_SQRT_GO = 4'd7;
   localparam logic [3:0] S_SQRT    = 4'd8;
   localparam logic [3:0] S_EMIT_RD = 4'd9;
   localparam logic [3:0] S_EMIT    = 4'd10;

   localparam logic [CNT_W-1:0] LAST_CNT = {IDX_W'(DIM - 1), 2'b11};
   localparam logic [NRM_W-1:0] LAST_NRM = {IDX_W'(DIM - 1), 1'b1};
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

   logic [3:0]        state_ff;
   logic              mode_ff;      // 0: A*X, kept as 2I - AX in scratch, 1: X*scratch into X
   logic [IDX_W-1:0]  row_ff;
   logic [IDX_W-1:0]  col_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_d_ff;
   logic              feed_v_ff;
   logic [NRM_W-1:0]  nrm_ff;
   logic [CPLX_W-1:0] sq_ff;
   logic              sq_v_ff;
   logic [CPLX_W-1:0] sum_ff;
   row_type           erow_ff;
   row_type           erow_in;
   row_type           srow;
   logic [DATA_W-1:0] prev_norm_ff;
   logic [7:0]        step_count_ff;
   logic [1:0]        status_ff;
   logic [30:0]       tol_ff;
   logic [30:0]       fluct_ff;
   logic [7:0]        limit_ff;

   logic              req_take;
   logic              load_ok;
   logic [DIM-1:0]    lane_sel;
   row_type           load_row;
   cplx_type          load_elem;
   ram_ctl_type       a_ctl;
   ram_ctl_type       x_ctl;
   ram_ctl_type       s_ctl;
   row_type           x_wr;
   row_type           a_rd;
   row_type           x_rd;
   row_type           s_rd;
   row_type           prow;
   row_type           qrow;
   cplx_type          p_elem;
   token_type         tok [DIM+1];
   cell_res_type      res [DIM];
   logic [DATA_W-1:0] nrm_val;
   logic signed [CPLX_W-1:0] nrm_sq;
   logic [CPLX_W:0]   sum_wide;
   logic              sqrt_done;
   logic [DATA_W-1:0] sqrt_root;
   logic [DATA_W:0]   threshold;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // load beat decode
   assign load_ok   = ({1'b0, req_row} < (IDX_W + 1)'(DIM))
                   && ({1'b0, req_col} < (IDX_W + 1)'(DIM));
   assign lane_sel  = {{(DIM - 1){1'b0}}, 1'b1} << req_col;
   assign load_elem = {req_real_part, req_imag_part};
   assign load_row  = row_type'({DIM{load_elem}});

   // store port control
   always_comb begin
      a_ctl = '0;
      x_ctl = '0;
      s_ctl = '0;
      x_wr  = load_row;
      a_ctl.wr_addr = req_row;
      x_ctl.wr_addr = req_row;
      a_ctl.rd_addr = row_ff;
      x_ctl.rd_addr = row_ff;
      s_ctl.wr_addr = row_ff;
      s_ctl.rd_addr = cnt_ff[CNT_W-1:2];
      if (req_take && load_ok && req_cmd == CMD_LOAD_A) begin
         a_ctl.wr_lane = lane_sel;
      end
      if (req_take && load_ok && req_cmd == CMD_LOAD_X) begin
         x_ctl.wr_lane = lane_sel;
      end
      unique case (state_ff)
         S_PREP: begin
            a_ctl.rd_en = !mode_ff;
            x_ctl.rd_en = mode_ff;
         end
         S_MUL: begin
            x_ctl.rd_en   = !mode_ff;
            x_ctl.rd_addr = cnt_ff[CNT_W-1:2];
            s_ctl.rd_en   = mode_ff;
         end
         S_WRITE: begin
            if (mode_ff) begin
               x_ctl.wr_lane = '1;
               x_ctl.wr_addr = row_ff;
               x_wr          = erow_ff;
            end else begin
               s_ctl.wr_lane = '1;
            end
         end
         S_EMIT_RD: x_ctl.rd_en = 1'b1;
         default: ;
      endcase
   end

   // scratch row with 1.0 added on the diagonal real part
   always_comb begin
      srow = erow_ff;
      for (int j = 0; j < DIM; j++) begin
         if (IDX_W'(j) == row_ff) begin
            srow[j].re = sat32(ext_acc(erow_ff[j].re) + ONE_ACC);
         end
      end
   end

   nsci_row_ram u_a_ram (.clock(clock), .ctl(a_ctl), .wr_data(load_row), .rd_data(a_rd));
   nsci_row_ram u_x_ram (.clock(clock), .ctl(x_ctl), .wr_data(x_wr),     .rd_data(x_rd));
   nsci_row_ram u_s_ram (.clock(clock), .ctl(s_ctl), .wr_data(srow),     .rd_data(s_rd));

   // operand selection and head beat of the chain
   assign prow   = mode_ff ? x_rd : a_rd;
   assign qrow   = mode_ff ? s_rd : x_rd;
   assign p_elem = prow[cnt_d_ff[CNT_W-1:2]];

   always_comb begin
      tok[0].valid = feed_v_ff;
      tok[0].head  = (cnt_d_ff == '0);
      tok[0].tail  = (cnt_d_ff == LAST_CNT);
      tok[0].part  = cnt_d_ff[1:0];
      tok[0].qrow  = qrow;
      unique case (cnt_d_ff[1:0])
         PART_RR, PART_RI: tok[0].a = p_elem.re;
         PART_II, PART_IR: tok[0].a = p_elem.im;
      endcase
   end

   // product cell chain
   for (genvar c = 0; c < DIM; c++) begin : g_cell
      nsci_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[c]),
         .tok_out (tok[c+1]),
         .res     (res[c])
      );
   end

   // finished product row, turned into I - AX in the first product
   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         erow_in[j] = res[j].value;
         if (!mode_ff) begin
            erow_in[j].re = sat32(((IDX_W'(j) == row_ff) ? ONE_ACC : '0)
                                  - ext_acc(res[j].value.re));
            erow_in[j].im = sat32('0 - ext_acc(res[j].value.im));
         end
      end
   end

   // squared norm, one part per cycle, saturating sum
   assign nrm_val  = nrm_ff[0] ? erow_ff[nrm_ff[NRM_W-1:1]].im
                               : erow_ff[nrm_ff[NRM_W-1:1]].re;
   assign nrm_sq   = $signed(nrm_val) * $signed(nrm_val);
   assign sum_wide = {1'b0, sum_ff} + {1'b0, sq_ff};

   nsci_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_SQRT_GO),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign threshold = {1'b0, prev_norm_ff} + {2'b00, fluct_ff};

   // payload pipeline registers
   always_ff @(posedge clock) begin
      cnt_d_ff <= cnt_ff;
      sq_ff    <= nrm_sq;
      if (state_ff == S_CHECK) begin
         sum_ff <= '0;
      end else if (sq_v_ff) begin
         sum_ff <= sum_wide[CPLX_W] ? '1 : sum_wide[CPLX_W-1:0];
      end
      if (state_ff == S_WAIT && res[DIM-1].done) begin
         erow_ff <= erow_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= 31'd1677;
         fluct_ff <= '0;
         limit_ff <= 8'd20;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TOLERANCE:   tol_ff   <= csr_data;
            CSR_FLUCTUATION: fluct_ff <= csr_data;
            CSR_LIMIT:       limit_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         cnt_ff        <= '0;
         nrm_ff        <= '0;
         feed_v_ff     <= 1'b0;
         sq_v_ff       <= 1'b0;
         prev_norm_ff  <= '1;
         step_count_ff <= '0;
         status_ff     <= STAT_LIMIT;
      end else begin
         feed_v_ff <= (state_ff == S_MUL);
         sq_v_ff   <= (state_ff == S_NORM);
         unique case (state_ff)
            S_IDLE: begin
               if (req_take && req_cmd == CMD_START) begin
                  prev_norm_ff  <= '1;
                  step_count_ff <= '0;
                  state_ff      <= S_CHECK;
               end
            end
            S_CHECK: begin
               row_ff <= '0;
               col_ff <= '0;
               if (step_count_ff < limit_ff) begin
                  mode_ff  <= 1'b0;
                  state_ff <= S_PREP;
               end else begin
                  status_ff <= STAT_LIMIT;
                  state_ff  <= S_EMIT_RD;
               end
            end
            S_PREP: begin
               cnt_ff   <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (cnt_ff == LAST_CNT) begin
                  state_ff <= S_WAIT;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            S_WAIT: begin
               if (res[DIM-1].done) begin
                  nrm_ff   <= '0;
                  state_ff <= mode_ff ? S_WRITE : S_NORM;
               end
            end
            S_NORM: begin
               if (nrm_ff == LAST_NRM) begin
                  state_ff <= S_WRITE;
               end else begin
                  nrm_ff <= nrm_ff + NRM_W'(1);
               end
            end
            S_WRITE: begin
               if (row_ff == LAST_IDX) begin
                  row_ff <= '0;
                  if (mode_ff) begin
                     step_count_ff <= step_count_ff + 8'd1;
                     state_ff      <= S_CHECK;
                  end else begin
                     state_ff <= S_SQRT_GO;
                  end
               end else begin
                  row_ff   <= row_ff + IDX_W'(1);
                  state_ff <= S_PREP;
               end
            end
            S_SQRT_GO: state_ff <= S_SQRT;
            S_SQRT: begin
               if (sqrt_done) begin
                  priority if (sqrt_root < {1'b0, tol_ff}) begin
                     status_ff <= STAT_CONVERGED;
                     state_ff  <= S_EMIT_RD;
                  end else if ({1'b0, sqrt_root} > threshold) begin
                     status_ff <= STAT_UNSTABLE;
                     state_ff  <= S_EMIT_RD;
                  end else begin
                     prev_norm_ff <= sqrt_root;
                     mode_ff      <= 1'b1;
                     state_ff     <= S_PREP;
                  end
               end
            end
            S_EMIT_RD: state_ff <= S_EMIT;
            S_EMIT: begin
               if (!rsp_stall) begin
                  if (col_ff == LAST_IDX) begin
                     col_ff <= '0;
                     if (row_ff == LAST_IDX) begin
                        row_ff   <= '0;
                        state_ff <= S_IDLE;
                     end else begin
                        row_ff   <= row_ff + IDX_W'(1);
                        state_ff <= S_EMIT_RD;
                     end
                  end else begin
                     col_ff <= col_ff + IDX_W'(1);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // result beat
   assign rsp_valid    = (state_ff == S_EMIT);
   assign rsp_out_row  = row_ff;
   assign rsp_out_col  = col_ff;
   assign rsp_out_real = x_rd[col_ff].re;
   assign rsp_out_imag = x_rd[col_ff].im;
   assign rsp_status   = status_ff;
   assign rsp_last     = (row_ff == LAST_IDX) && (col_ff == LAST_IDX);

endmodule

[design/nsci_checker.sv]
// ----------------------------------------------------------------------------
// nsci_checker
// Port-level checks of the Newton-Schulz complex inverse unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nsci_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [1:0]                 req_cmd,
   input logic [nsci_pkg::IDX_W-1:0] req_row,
   input logic [nsci_pkg::IDX_W-1:0] req_col,
   input logic signed [31:0]         req_real_part,
   input logic signed [31:0]         req_imag_part,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [nsci_pkg::IDX_W-1:0] rsp_out_row,
   input logic [nsci_pkg::IDX_W-1:0] rsp_out_col,
   input logic signed [31:0]         rsp_out_real,
   input logic signed [31:0]         rsp_out_imag,
   input logic [1:0]                 rsp_status,
   input logic                       rsp_last,
   input logic                       csr_write,
   input logic [1:0]                 csr_index,
   input logic [30:0]                csr_data
);
   import nsci_pkg::*;

   // a held result beat keeps its value
   `NSCI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_real) && $stable(rsp_out_imag), "result beat changed while stalled")

   // no input beat is taken while results are going out
   `NSCI_ASSERT(a_busy_emit, clock, reset, rsp_valid |-> req_stall, "input open during result burst")

   // the final beat closes the burst
   `NSCI_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && !rsp_stall && rsp_last, !rsp_valid, "result beat after the final one")

   // columns of a row come out in order without a gap
   `NSCI_ASSERT_NEXT(a_col_step, clock, reset, rsp_valid && !rsp_stall && rsp_out_col != IDX_W'(DIM - 1), rsp_valid && rsp_out_col == $past(rsp_out_col) + IDX_W'(1), "column order broken")

endmodule

bind newton_schulz_complex_inverse_unit nsci_checker u_nsci_checker (.*);

[test/newton_schulz_complex_inverse_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_schulz_complex_inverse_unit_checker
// Watches the req, rsp and csr ports, predicts the emitted inverse elements
// of every start beat and compares each rsp beat with the oldest prediction.
// ----------------------------------------------------------------------------
module newton_schulz_complex_inverse_unit_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_cmd,
   input  logic [nsci_pkg::IDX_W-1:0] req_row,
   input  logic [nsci_pkg::IDX_W-1:0] req_col,
   input  logic signed [31:0]         req_real_part,
   input  logic signed [31:0]         req_imag_part,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [nsci_pkg::IDX_W-1:0] rsp_out_row,
   input  logic [nsci_pkg::IDX_W-1:0] rsp_out_col,
   input  logic signed [31:0]         rsp_out_real,
   input  logic signed [31:0]         rsp_out_imag,
   input  logic [1:0]                 rsp_status,
   input  logic                       rsp_last,
   input  logic                       csr_write,
   input  logic [1:0]                 csr_index,
   input  logic [30:0]                csr_data,
   output int                         errors,
   output int                         pending
);
   import nsci_pkg::*;

   // refinement outcome beside the status codes: go on with the next step
   localparam logic [1:0] STEP_CONTINUE = 2'd3;
   localparam longint     ONE_Q24       = 64'sd1 << 24;

   typedef struct {
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic [1:0]         status;
      logic               last;
   } element_type;

   element_type        inverse_q[$];

   logic signed [31:0] a_re [64], a_im [64];
   logic signed [31:0] x_re [64], x_im [64];
   logic signed [31:0] e_re [64], e_im [64];
   logic signed [31:0] n_re [64], n_im [64];
   logic [31:0]        prev_norm;
   logic [30:0]        tolerance;
   logic [30:0]        allowance;
   logic [7:0]         step_limit;

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint floor_prod(input logic signed [31:0] p,
                                         input logic signed [31:0] q);
      return (longint'(p) * longint'(q)) >>> 24;
   endfunction

   function automatic logic [31:0] root64(input logic [63:0] v);
      logic [63:0] rem, res, probe;
      rem = v;
      res = 0;
      probe = 64'h1 << 62;
      while (probe > v) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= res + probe) begin
            rem = rem - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res[31:0];
   endfunction

   // second = 0: e = a * x, second = 1: n = x * e
   task automatic form_product(input bit second);
      longint sr, si;
      logic signed [31:0] pr, pi, qr, qi;
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            sr = 0;
            si = 0;
            for (int k = 0; k < DIM; k++) begin
               pr = second ? x_re[i*8+k] : a_re[i*8+k];
               pi = second ? x_im[i*8+k] : a_im[i*8+k];
               qr = second ? e_re[k*8+j] : x_re[k*8+j];
               qi = second ? e_im[k*8+j] : x_im[k*8+j];
               sr = sr + floor_prod(pr, qr) - floor_prod(pi, qi);
               si = si + floor_prod(pr, qi) + floor_prod(pi, qr);
            end
            if (second) begin
               n_re[i*8+j] = clamp32(sr);
               n_im[i*8+j] = clamp32(si);
            end else begin
               e_re[i*8+j] = clamp32(sr);
               e_im[i*8+j] = clamp32(si);
            end
         end
      end
   endtask

   // one Newton-Schulz step with the norm checks
   task automatic refine_step(output logic [1:0] outcome);
      logic [64:0] sq;
      logic [31:0] norm;
      longint      d;
      form_product(1'b0);
      sq = 0;
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            d = (i == j) ? ONE_Q24 : 0;
            e_re[i*8+j] = clamp32(d - longint'(e_re[i*8+j]));
            e_im[i*8+j] = clamp32(-longint'(e_im[i*8+j]));
            sq = sq + 65'(longint'(e_re[i*8+j]) * longint'(e_re[i*8+j]));
            if (sq[64]) sq = {1'b0, {64{1'b1}}};
            sq = sq + 65'(longint'(e_im[i*8+j]) * longint'(e_im[i*8+j]));
            if (sq[64]) sq = {1'b0, {64{1'b1}}};
         end
      end
      norm = root64(sq[63:0]);
      if (norm < {1'b0, tolerance}) begin
         outcome = STAT_CONVERGED;
      end else if ({1'b0, norm} > {1'b0, prev_norm} + {2'b0, allowance}) begin
         outcome = STAT_UNSTABLE;
      end else begin
         prev_norm = norm;
         for (int i = 0; i < DIM; i++)
            e_re[i*8+i] = clamp32(longint'(e_re[i*8+i]) + ONE_Q24);
         form_product(1'b1);
         x_re = n_re;
         x_im = n_im;
         outcome = STEP_CONTINUE;
      end
   endtask

   // start beat: iterate, then queue every element of the estimate
   task automatic predict_inverse();
      logic [1:0]  status, outcome;
      element_type b;
      prev_norm = 32'hFFFFFFFF;
      status = STAT_LIMIT;
      for (int k = 0; k < step_limit; k++) begin
         refine_step(outcome);
         if (outcome != STEP_CONTINUE) begin
            status = outcome;
            break;
         end
      end
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            b.row = i;
            b.col = j;
            b.re = x_re[i*8+j];
            b.im = x_im[i*8+j];
            b.status = status;
            b.last = (i == DIM-1) && (j == DIM-1);
            inverse_q.push_back(b);
         end
      end
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      pending = 0;
      tolerance = 31'd1677;
      allowance = 0;
      step_limit = 8'd20;
   end

   // watch the channels at each rising edge
   always @(posedge clock) begin
      element_type b;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               CSR_TOLERANCE:   tolerance = csr_data;
               CSR_FLUCTUATION: allowance = csr_data;
               CSR_LIMIT:       step_limit = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_LOAD_A: begin
                  a_re[req_row*8+req_col] = req_real_part;
                  a_im[req_row*8+req_col] = req_imag_part;
               end
               CMD_LOAD_X: begin
                  x_re[req_row*8+req_col] = req_real_part;
                  x_im[req_row*8+req_col] = req_imag_part;
               end
               CMD_START: predict_inverse();
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (inverse_q.size() == 0) begin
               $display("%0t: unexpected rsp beat, expected none actual row %0d col %0d",
                        $time, rsp_out_row, rsp_out_col);
               errors++;
            end else begin
               b = inverse_q.pop_front();
               check_field("row", b.row, rsp_out_row);
               check_field("col", b.col, rsp_out_col);
               check_field("real", b.re, rsp_out_real);
               check_field("imag", b.im, rsp_out_imag);
               check_field("status", b.status, rsp_status);
               check_field("last", b.last, rsp_last);
            end
         end
         pending = inverse_q.size();
      end
   end

endmodule

[test/newton_schulz_complex_inverse_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_schulz_complex_inverse_unit_tb
// Loads matrices and starting guesses, starts refinements under several
// register settings and idling patterns; the checker compares every element.
// ----------------------------------------------------------------------------
module newton_schulz_complex_inverse_unit_tb;
   import nsci_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [IDX_W-1:0]   req_row;
   logic [IDX_W-1:0]   req_col;
   logic signed [31:0] req_real_part;
   logic signed [31:0] req_imag_part;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [IDX_W-1:0]   rsp_out_row;
   logic [IDX_W-1:0]   rsp_out_col;
   logic signed [31:0] rsp_out_real;
   logic signed [31:0] rsp_out_imag;
   logic [1:0]         rsp_status;
   logic               rsp_last;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [30:0]        csr_data;
   int                 errors;
   int                 pending;
   int                 idle_pct;
   int                 stall_pct;

   newton_schulz_complex_inverse_unit dut (.*);

   newton_schulz_complex_inverse_unit_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("newton_schulz_complex_inverse_unit: mismatch");
      $finish;
   end

   // receiver stall pattern
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one req beat, entered and left at a falling edge
   task automatic send_beat(input logic [1:0] cmd, input int row, input int col,
                            input logic [31:0] re, input logic [31:0] im);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_row = row;
      req_col = col;
      req_real_part = re;
      req_imag_part = im;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [30:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // hold the sender until every element has come back
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic configure(input logic [30:0] tol, input logic [30:0] allow,
                            input logic [7:0] steps);
      drain();
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_FLUCTUATION, allow);
      write_reg(CSR_LIMIT, {23'd0, steps});
   endtask

   function automatic logic [31:0] small_value(input int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   initial begin
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_LOAD_A;
      req_row = 0;
      req_col = 0;
      req_real_part = 0;
      req_imag_part = 0;
      csr_write = 1'b0;
      csr_index = CSR_TOLERANCE;
      csr_data = 0;
      rsp_stall = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extreme values, the unused command, exact identity
      send_beat(CMD_LOAD_A, 7, 7, 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(CMD_LOAD_X, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(CMD_SPARE, 7, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            send_beat(CMD_LOAD_A, i, j, (i == j) ? 32'h0100_0000 : 0, 0);
            send_beat(CMD_LOAD_X, i, j, (i == j) ? 32'h0100_0000 : 0, 0);
         end
      end
      send_beat(CMD_START, 0, 0, 0, 0);
      configure(31'd1677, 31'd0, 8'd0);
      send_beat(CMD_START, 0, 0, 0, 0);
      // zero tolerance never converges: full run of the largest limit
      configure(31'd0, 31'h7FFF_FFFF, 8'd255);
      send_beat(CMD_START, 0, 0, 0, 0);
      configure(31'h7FFF_FFFF, 31'd0, 8'd20);
      send_beat(CMD_START, 0, 0, 0, 0);

      // random part on top of the identity, four idling patterns
      for (phase = 0; phase < 4; phase++) begin
         drain();
         case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 88; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 88; end
            default: begin idle_pct = 11; stall_pct = 11; end
         endcase
         for (int s = 0; s < 3; s++) begin
            case ($urandom_range(3))
               0: configure(31'd0, $urandom_range(1 << 24), $urandom_range(1, 4));
               1: configure($urandom_range(1 << 20), 0, $urandom_range(1, 12));
               default: configure(31'd1677, $urandom_range(1 << 16),
                                  $urandom_range(1, 12));
            endcase
            // mostly small nudges of A; now and then a wild element or a stray command
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(9))
                  0: send_beat($urandom_range(1), $urandom_range(7), $urandom_range(7),
                               $urandom, $urandom);
                  1: send_beat(CMD_SPARE, $urandom_range(7), $urandom_range(7),
                               $urandom, $urandom);
                  default: send_beat(CMD_LOAD_A, $urandom_range(7), $urandom_range(7),
                                     small_value(1 << 16), small_value(1 << 16));
               endcase
            end
            send_beat(CMD_START, $urandom_range(7), $urandom_range(7), $urandom, $urandom);
            // repeated start continues from the last estimate
            if ($urandom_range(3) == 0)
               send_beat(CMD_START, 0, 0, 0, 0);
         end
      end

      // saturating garbage in one element of A and one of X drives the norm up
      configure(31'd1677, 31'd0, 8'd6);
      send_beat(CMD_LOAD_A, 3, 4, 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(CMD_LOAD_X, 3, 3, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(CMD_START, 0, 0, 0, 0);

      drain();
      repeat (200) @(negedge clock);
      if (errors == 0) begin
         $display("newton_schulz_complex_inverse_unit: match");
      end else begin
         $display("newton_schulz_complex_inverse_unit: mismatch");
      end
      $finish;
   end

endmodule
